@@ design/sslcd_pkg.sv @@
// Shared types, constants and the big-digit glyph table of the LCD frame formatter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package sslcd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPEED_SCALE = 2'd0;
    localparam logic [1:0] CFG_RPM_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_STALE_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [23:0] SPEED_SCALE_RESET = 24'd31467;
    localparam logic [15:0] RPM_OFFSET_RESET  = 16'd20000;
    localparam logic [15:0] STALE_LIMIT_RESET = 16'd2000;

    // Default depth of the queue between front and back (range 2 to 16)
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Expander bit positions
    localparam logic [7:0] BIT_BL = 8'h08;
    localparam logic [7:0] BIT_EN = 8'h04;

    // Display geometry and commands
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW0_BASE     = 8'h00;
    localparam logic [7:0] ROW1_BASE     = 8'h40;
    localparam logic [7:0] ROW2_BASE     = 8'h14;
    localparam logic [4:0] LAST_COL      = 5'd20;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] GL_T     = 8'h08;
    localparam logic [7:0] GL_B     = 8'h09;
    localparam logic [7:0] GL_F     = 8'h0A;

    // Glyph table: each word is {top0, top1, top2, bot0, bot1, bot2}.
    localparam logic [47:0] GLYPH_TABLE [10] = '{
        {GL_F, GL_T, GL_F, GL_F, GL_B, GL_F},
        {CH_SPACE, GL_F, CH_SPACE, CH_SPACE, GL_F, CH_SPACE},
        {GL_T, GL_T, GL_F, GL_F, GL_B, GL_B},
        {GL_T, GL_T, GL_F, GL_B, GL_B, GL_F},
        {GL_F, GL_B, GL_F, CH_SPACE, CH_SPACE, GL_F},
        {GL_F, GL_T, GL_T, GL_B, GL_B, GL_F},
        {GL_F, GL_T, GL_T, GL_F, GL_B, GL_F},
        {GL_T, GL_T, GL_F, CH_SPACE, CH_SPACE, GL_F},
        {GL_F, GL_F, GL_F, GL_F, GL_B, GL_F},
        {GL_F, GL_T, GL_F, GL_B, GL_B, GL_F}
    };

    // Configuration register set
    typedef struct packed {
        logic [23:0] speed_scale_q24;
        logic [15:0] rpm_zero_offset;
        logic [15:0] stale_limit_ms;
    } cfg_t;

    // One classified refresh request, as decimal digits
    typedef struct packed {
        logic       stale;
        logic       soc_hund;
        logic [3:0] soc_tens;
        logic [3:0] soc_units;
        logic [3:0] soc_frac;
        logic [3:0] spd_hund;
        logic [3:0] spd_tens;
        logic [3:0] spd_units;
    } frame_desc_t;

endpackage

@@ design/sslcd_front.sv @@
// Front end: accepts refresh requests, checks staleness, scales the speed and
// splits speed and charge into decimal digits. Depends on sslcd_pkg.
`timescale 1ns / 1ps

module sslcd_front #(
    parameter int QUEUE_DEPTH = sslcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   data_valid,
    input  logic [31:0]            now_ms,
    input  logic [31:0]            last_rx_ms,
    input  logic [15:0]            rpm_raw,
    input  logic [9:0]             charge_raw,
    input  sslcd_pkg::cfg_t        cfg,
    input  logic                   pop,
    output logic                   push,
    output sslcd_pkg::frame_desc_t push_data
);
    import sslcd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CREDIT_MAX = CW'(QUEUE_DEPTH);

    logic          accept;
    logic [CW-1:0] credit_reg;
    logic [CW-1:0] credit_next;
    logic [5:1]    vld_reg;

    logic [31:0] age;
    logic [9:0]  csat;

    // Stage 1 registers
    logic        s1_stale_reg;
    logic [15:0] s1_diff_reg;
    logic [9:0]  s1_charge_reg;

    // Stage 2
    logic [39:0] spd_prod;
    logic [17:0] cq_prod;
    logic        s2_stale_reg;
    logic [9:0]  s2_spd_reg;
    logic [9:0]  s2_charge_reg;
    logic [6:0]  s2_cq_reg;

    // Stage 3
    logic [15:0] sh_prod;
    logic [9:0]  cfr_full;
    logic [14:0] ct_prod;
    logic        s3_stale_reg;
    logic [9:0]  s3_spd_reg;
    logic [3:0]  s3_sh_reg;
    logic [3:0]  s3_cfr_reg;
    logic [6:0]  s3_cq_reg;
    logic [3:0]  s3_ct_reg;

    // Stage 4
    logic [9:0]  srem_full;
    logic [6:0]  cu_full;
    logic        s4_stale_reg;
    logic [6:0]  s4_srem_reg;
    logic [3:0]  s4_sh_reg;
    logic        s4_chund_reg;
    logic [3:0]  s4_ctens_reg;
    logic [3:0]  s4_cunits_reg;
    logic [3:0]  s4_cfr_reg;

    // Stage 5
    logic [14:0] st_prod;
    logic [6:0]  su_full;
    logic        s5_stale_reg;
    logic [6:0]  s5_srem_reg;
    logic [3:0]  s5_sh_reg;
    logic [3:0]  s5_st_reg;
    logic        s5_chund_reg;
    logic [3:0]  s5_ctens_reg;
    logic [3:0]  s5_cunits_reg;
    logic [3:0]  s5_cfr_reg;

    // Credits count items in the pipeline plus items held in the queue.
    assign in_ready    = (credit_reg < CREDIT_MAX);
    assign accept      = in_valid && in_ready;
    assign credit_next = credit_reg + CW'(accept) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg    <= {vld_reg[4:1], accept};
        end
    end

    // Stage 1: age check, offset removal and charge saturation.
    assign age  = now_ms - last_rx_ms;
    assign csat = (charge_raw > 10'd1000) ? 10'd1000 : charge_raw;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stale_reg  <= !data_valid || (age > {16'd0, cfg.stale_limit_ms});
            s1_diff_reg   <= (rpm_raw >= cfg.rpm_zero_offset) ?
                             (rpm_raw - cfg.rpm_zero_offset) :
                             (cfg.rpm_zero_offset - rpm_raw);
            s1_charge_reg <= csat;
        end
    end

    // Stage 2: Q24 scaling with rounding and saturation; charge divided by ten.
    assign spd_prod = ({24'd0, s1_diff_reg} * {16'd0, cfg.speed_scale_q24})
                      + 40'h0000800000;
    assign cq_prod  = {8'd0, s1_charge_reg} * 18'd205;

    always_ff @(posedge clk)
    begin
        s2_stale_reg  <= s1_stale_reg;
        s2_spd_reg    <= (spd_prod[39:24] > 16'd999) ? 10'd999 : spd_prod[33:24];
        s2_charge_reg <= s1_charge_reg;
        s2_cq_reg     <= cq_prod[17:11];
    end

    // Stage 3: speed hundreds, charge tenth and charge tens.
    assign sh_prod  = {6'd0, s2_spd_reg} * 16'd41;
    assign cfr_full = s2_charge_reg - ({3'd0, s2_cq_reg} * 10'd10);
    assign ct_prod  = {8'd0, s2_cq_reg} * 15'd205;

    always_ff @(posedge clk)
    begin
        s3_stale_reg <= s2_stale_reg;
        s3_spd_reg   <= s2_spd_reg;
        s3_sh_reg    <= sh_prod[15:12];
        s3_cfr_reg   <= cfr_full[3:0];
        s3_cq_reg    <= s2_cq_reg;
        s3_ct_reg    <= ct_prod[14:11];
    end

    // Stage 4: speed remainder below a hundred; charge integer digits.
    assign srem_full = s3_spd_reg - ({6'd0, s3_sh_reg} * 10'd100);
    assign cu_full   = s3_cq_reg - ({3'd0, s3_ct_reg} * 7'd10);

    always_ff @(posedge clk)
    begin
        s4_stale_reg  <= s3_stale_reg;
        s4_srem_reg   <= srem_full[6:0];
        s4_sh_reg     <= s3_sh_reg;
        // A quotient of ten means the integer part is exactly one hundred.
        s4_chund_reg  <= (s3_ct_reg == 4'd10);
        s4_ctens_reg  <= (s3_ct_reg == 4'd10) ? 4'd0 : s3_ct_reg;
        s4_cunits_reg <= cu_full[3:0];
        s4_cfr_reg    <= s3_cfr_reg;
    end

    // Stage 5: speed tens.
    assign st_prod = {8'd0, s4_srem_reg} * 15'd205;

    always_ff @(posedge clk)
    begin
        s5_stale_reg  <= s4_stale_reg;
        s5_srem_reg   <= s4_srem_reg;
        s5_sh_reg     <= s4_sh_reg;
        s5_st_reg     <= st_prod[14:11];
        s5_chund_reg  <= s4_chund_reg;
        s5_ctens_reg  <= s4_ctens_reg;
        s5_cunits_reg <= s4_cunits_reg;
        s5_cfr_reg    <= s4_cfr_reg;
    end

    // Final step: speed units, then the descriptor goes into the queue.
    assign su_full = s5_srem_reg - ({3'd0, s5_st_reg} * 7'd10);

    always_comb
    begin
        push                = vld_reg[5];
        push_data.stale     = s5_stale_reg;
        push_data.soc_hund  = s5_chund_reg;
        push_data.soc_tens  = s5_ctens_reg;
        push_data.soc_units = s5_cunits_reg;
        push_data.soc_frac  = s5_cfr_reg;
        push_data.spd_hund  = s5_sh_reg;
        push_data.spd_tens  = s5_st_reg;
        push_data.spd_units = su_full[3:0];
    end

endmodule

@@ design/sslcd_queue.sv @@
// Small register queue of frame descriptors between front and back.
// Depends on sslcd_pkg.
`timescale 1ns / 1ps

module sslcd_queue #(
    parameter int QUEUE_DEPTH = sslcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sslcd_pkg::frame_desc_t push_data,
    input  logic                   pop,
    output logic                   head_valid,
    output sslcd_pkg::frame_desc_t head
);
    import sslcd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);

    frame_desc_t   mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/sslcd_back.sv @@
// Back end: walks the head descriptor's three display rows, one write per
// unstalled cycle, into the output register. Depends on sslcd_pkg.
`timescale 1ns / 1ps

module sslcd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  sslcd_pkg::frame_desc_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_data,
    output logic [7:0]             lcd_byte,
    output logic [7:0]             wire0,
    output logic [7:0]             wire1,
    output logic [7:0]             wire2,
    output logic [7:0]             wire3,
    output logic                   last_of_frame
);
    import sslcd_pkg::*;

    // Picks one glyph character: digit, bottom half flag, column within glyph.
    function automatic logic [7:0] glyph_byte(input logic [3:0] d, input logic bot,
                                              input logic [1:0] i);
        logic [47:0] w;
        logic [23:0] half;
        w = (d <= 4'd9) ? GLYPH_TABLE[d] : GLYPH_TABLE[0];
        half = bot ? w[23:0] : w[47:24];
        case (i)
            2'd0:    glyph_byte = half[23:16];
            2'd1:    glyph_byte = half[15:8];
            default: glyph_byte = half[7:0];
        endcase
    endfunction

    function automatic logic [7:0] ascii_digit(input logic [3:0] d);
        ascii_digit = 8'h30 | {4'd0, d};
    endfunction

    logic [1:0] row_reg;
    logic [4:0] col_reg;
    logic       out_valid_reg;
    logic       is_data_reg;
    logic [7:0] lcd_byte_reg;
    logic       last_reg;

    logic       advance;
    logic       fire;
    logic       last_write;
    logic [4:0] c;
    logic [3:0] tail_idx;
    logic [7:0] tail [10];
    logic [7:0] row0_char;
    logic [7:0] big_char;
    logic [7:0] next_byte;
    logic       show_hund;
    logic       show_tens;

    // Sequencer control
    assign advance    = !out_valid_reg || out_ready;
    assign fire       = advance && head_valid;
    assign last_write = (row_reg == 2'd2) && (col_reg == LAST_COL);
    assign pop        = fire && last_write;

    // Right-hand ten columns of row 0: the charge text, right-aligned.
    always_comb
    begin
        tail[0] = "S";
        tail[1] = "O";
        tail[2] = "C";
        tail[3] = ":";
        tail[4] = " ";
        tail[5] = "-";
        tail[6] = "-";
        tail[7] = ".";
        tail[8] = "-";
        tail[9] = "%";
        if (!head.stale)
        begin
            tail[7] = ".";
            tail[8] = ascii_digit(head.soc_frac);
            tail[9] = "%";
            tail[6] = ascii_digit(head.soc_units);
            if (head.soc_hund)
            begin
                tail[4] = ascii_digit(4'd1);
                tail[5] = ascii_digit(head.soc_tens);
            end
            else if (head.soc_tens != 4'd0)
            begin
                tail[0] = CH_SPACE;
                tail[1] = "S";
                tail[2] = "O";
                tail[3] = "C";
                tail[4] = ":";
                tail[5] = ascii_digit(head.soc_tens);
            end
            else
            begin
                tail[0] = CH_SPACE;
                tail[1] = CH_SPACE;
                tail[2] = "S";
                tail[3] = "O";
                tail[4] = "C";
                tail[5] = ":";
            end
        end
    end

    assign c        = col_reg - 5'd1;
    assign tail_idx = 4'(c - 5'd10);
    assign row0_char = (c >= 5'd10) ? tail[tail_idx] : CH_SPACE;

    // Rows 1 and 2: big digits, or the no-signal text when stale.
    assign show_hund = (head.spd_hund != 4'd0);
    assign show_tens = show_hund || (head.spd_tens != 4'd0);

    always_comb
    begin
        big_char = CH_SPACE;
        if (head.stale)
        begin
            if (row_reg == 2'd1)
            begin
                case (c)
                    5'd6:    big_char = "N";
                    5'd7:    big_char = "O";
                    5'd8:    big_char = " ";
                    5'd9:    big_char = "S";
                    5'd10:   big_char = "I";
                    5'd11:   big_char = "G";
                    5'd12:   big_char = "N";
                    5'd13:   big_char = "A";
                    5'd14:   big_char = "L";
                    default: big_char = CH_SPACE;
                endcase
            end
        end
        else
        begin
            if ((c >= 5'd4) && (c <= 5'd6) && show_hund)
            begin
                big_char = glyph_byte(head.spd_hund, row_reg[1], 2'(c - 5'd4));
            end
            else if ((c >= 5'd8) && (c <= 5'd10) && show_tens)
            begin
                big_char = glyph_byte(head.spd_tens, row_reg[1], 2'(c - 5'd8));
            end
            else if ((c >= 5'd12) && (c <= 5'd14))
            begin
                big_char = glyph_byte(head.spd_units, row_reg[1], 2'(c - 5'd12));
            end
        end
    end

    // Byte for the current write: cursor command in column slot zero.
    always_comb
    begin
        if (col_reg == 5'd0)
        begin
            case (row_reg)
                2'd0:    next_byte = CMD_SET_DDRAM | ROW0_BASE;
                2'd1:    next_byte = CMD_SET_DDRAM | ROW1_BASE;
                default: next_byte = CMD_SET_DDRAM | ROW2_BASE;
            endcase
        end
        else if (row_reg == 2'd0)
        begin
            next_byte = row0_char;
        end
        else
        begin
            next_byte = big_char;
        end
    end

    // Row and column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= head_valid;
            end
            if (fire)
            begin
                if (col_reg == LAST_COL)
                begin
                    col_reg <= '0;
                    row_reg <= last_write ? 2'd0 : row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + 5'd1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            is_data_reg  <= (col_reg != 5'd0);
            lcd_byte_reg <= next_byte;
            last_reg     <= last_write;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_data       = is_data_reg;
    assign lcd_byte      = lcd_byte_reg;
    assign last_of_frame = last_reg;
    assign wire0 = {lcd_byte_reg[7:4], 4'd0} | BIT_BL | BIT_EN | {7'd0, is_data_reg};
    assign wire1 = {lcd_byte_reg[7:4], 4'd0} | BIT_BL | {7'd0, is_data_reg};
    assign wire2 = {lcd_byte_reg[3:0], 4'd0} | BIT_BL | BIT_EN | {7'd0, is_data_reg};
    assign wire3 = {lcd_byte_reg[3:0], 4'd0} | BIT_BL | {7'd0, is_data_reg};

endmodule

@@ design/speed_soc_lcd_frame_formatter.sv @@
// Top level of the speed and charge LCD frame formatter: configuration
// registers and the front, queue and back parts. Depends on sslcd_pkg.
//
//  Channel | Handshake             | Carries
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | data_valid, now_ms, last_rx_ms, rpm_raw,
//          |                       | charge_raw
//  out     | out_valid / out_ready | is_data, lcd_byte, wire0..wire3,
//          |                       | last_of_frame
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Each request produces 63 writes, one per cycle from the back sequencer while
// the output does not stall; the first write passes the front stages, the
// queue and the back output register before it is on the output.
// The front accepts a new request whenever fewer than QUEUE_DEPTH requests are
// in its stages or the queue, also while earlier writes are still going out.
// Output stalls hold the current write and freeze the sequencer only.
// Reset restores the configuration defaults and empties the pipeline.
`timescale 1ns / 1ps

module speed_soc_lcd_frame_formatter #(
    parameter int QUEUE_DEPTH = sslcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        data_valid,
    input  logic [31:0] now_ms,
    input  logic [31:0] last_rx_ms,
    input  logic [15:0] rpm_raw,
    input  logic [9:0]  charge_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_data,
    output logic [7:0]  lcd_byte,
    output logic [7:0]  wire0,
    output logic [7:0]  wire1,
    output logic [7:0]  wire2,
    output logic [7:0]  wire3,
    output logic        last_of_frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sslcd_pkg::*;

    cfg_t        cfg_reg;
    logic        push;
    logic        pop;
    logic        head_valid;
    frame_desc_t push_data;
    frame_desc_t head;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_scale_q24 <= SPEED_SCALE_RESET;
            cfg_reg.rpm_zero_offset <= RPM_OFFSET_RESET;
            cfg_reg.stale_limit_ms  <= STALE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SPEED_SCALE: cfg_reg.speed_scale_q24 <= cfg_data;
                CFG_RPM_OFFSET:  cfg_reg.rpm_zero_offset <= cfg_data[15:0];
                CFG_STALE_LIMIT: cfg_reg.stale_limit_ms  <= cfg_data[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end
    sslcd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_valid (data_valid),
        .now_ms     (now_ms),
        .last_rx_ms (last_rx_ms),
        .rpm_raw    (rpm_raw),
        .charge_raw (charge_raw),
        .cfg        (cfg_reg),
        .pop        (pop),
        .push       (push),
        .push_data  (push_data)
    );

    // Descriptor queue
    sslcd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end
    sslcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_data       (is_data),
        .lcd_byte      (lcd_byte),
        .wire0         (wire0),
        .wire1         (wire1),
        .wire2         (wire2),
        .wire3         (wire3),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ dv/lcd_frame_checker.sv @@
// Checker for the speed and charge LCD frame formatter: it watches the request,
// write and configuration channels, predicts every display write and compares.
// Depends on sslcd_pkg for register indexes, reset values and character codes.
`timescale 1ns / 1ps

module lcd_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        data_valid,
    input  logic [31:0] now_ms,
    input  logic [31:0] last_rx_ms,
    input  logic [15:0] rpm_raw,
    input  logic [9:0]  charge_raw,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        is_data,
    input  logic [7:0]  lcd_byte,
    input  logic [7:0]  wire0,
    input  logic [7:0]  wire1,
    input  logic [7:0]  wire2,
    input  logic [7:0]  wire3,
    input  logic        last_of_frame,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          mismatch_count,
    output int          writes_outstanding,
    output int          writes_checked
);

    import sslcd_pkg::*;

    localparam int WRITES_PER_FRAME = 63;
    localparam int COLS             = 20;
    localparam int MAX_REPORTS      = 30;

    // One display write as it leaves the block.
    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic [7:0] wire0;
        logic [7:0] wire1;
        logic [7:0] wire2;
        logic [7:0] wire3;
        logic       last_of_frame;
    } lcd_write_t;

    // Shadow copy of the configuration registers.
    logic [23:0] scale_q24;
    logic [15:0] zero_offset;
    logic [15:0] age_limit;

    lcd_write_t writes_due[$];
    lcd_write_t oldest;
    int         fail_total    = 0;
    int         checked_total = 0;
    int         pending       = 0;

    assign mismatch_count     = fail_total;
    assign writes_outstanding = pending;
    assign writes_checked     = checked_total;

    // Big-digit cells of one decimal digit: top row of three, then bottom row.
    function automatic logic [47:0] digit_cells(input logic [3:0] d);
        case (d)
            4'd0:    digit_cells = {GL_F, GL_T, GL_F, GL_F, GL_B, GL_F};
            4'd1:    digit_cells = {CH_SPACE, GL_F, CH_SPACE, CH_SPACE, GL_F, CH_SPACE};
            4'd2:    digit_cells = {GL_T, GL_T, GL_F, GL_F, GL_B, GL_B};
            4'd3:    digit_cells = {GL_T, GL_T, GL_F, GL_B, GL_B, GL_F};
            4'd4:    digit_cells = {GL_F, GL_B, GL_F, CH_SPACE, CH_SPACE, GL_F};
            4'd5:    digit_cells = {GL_F, GL_T, GL_T, GL_B, GL_B, GL_F};
            4'd6:    digit_cells = {GL_F, GL_T, GL_T, GL_F, GL_B, GL_F};
            4'd7:    digit_cells = {GL_T, GL_T, GL_F, CH_SPACE, CH_SPACE, GL_F};
            4'd8:    digit_cells = {GL_F, GL_F, GL_F, GL_F, GL_B, GL_F};
            4'd9:    digit_cells = {GL_F, GL_T, GL_F, GL_B, GL_B, GL_F};
            default: digit_cells = {6{CH_SPACE}};
        endcase
    endfunction

    // Splits a display byte into the four expander bytes, enable pulsed.
    function automatic lcd_write_t expander_write(input logic [7:0] b, input logic rs,
                                                  input int k);
        logic [7:0] hi;
        logic [7:0] lo;
        lcd_write_t w;
        hi = {b[7:4], 4'h0} | BIT_BL | {7'b0, rs};
        lo = {b[3:0], 4'h0} | BIT_BL | {7'b0, rs};
        w.is_data       = rs;
        w.lcd_byte      = b;
        w.wire0         = hi | BIT_EN;
        w.wire1         = hi;
        w.wire2         = lo | BIT_EN;
        w.wire3         = lo;
        w.last_of_frame = (k == WRITES_PER_FRAME - 1);
        return w;
    endfunction

    // Renders the three rows of one refresh request and queues its 63 writes.
    function automatic void render_frame(input logic valid, input logic [31:0] now_tick,
                                         input logic [31:0] rx_tick,
                                         input logic [15:0] rpm,
                                         input logic [9:0] charge);
        logic [7:0]  rows [0:2][0:COLS-1];
        logic [7:0]  base;
        logic [31:0] age;
        logic [15:0] diff;
        logic [40:0] product;
        logic [47:0] cells;
        logic        stale;
        logic        shown;
        string       text;
        int unsigned pct, kmh, hund, tens, units, digit;
        int          r, c, p, i, k;
        age   = now_tick - rx_tick;
        stale = !valid || (age > {16'b0, age_limit});
        for (r = 0; r < 3; r++)
            for (c = 0; c < COLS; c++)
                rows[r][c] = CH_SPACE;

        // Charge row, right-aligned; anything above 100.0 % reads as 100.0 %.
        if (stale)
            text = "SOC: --.-%";
        else
        begin
            pct  = (charge > 10'd1000) ? 1000 : charge;
            text = $sformatf("SOC:%0d.%0d%%", pct / 10, pct % 10);
        end
        for (i = 0; i < text.len(); i++)
            rows[0][COLS - text.len() + i] = text[i];

        // Speed rows, or the lost-signal notice.
        if (stale)
        begin
            text = "NO SIGNAL";
            for (i = 0; i < text.len(); i++)
                rows[1][6 + i] = text[i];
        end
        else
        begin
            diff    = (rpm >= zero_offset) ? rpm - zero_offset : zero_offset - rpm;
            product = {25'b0, diff} * {17'b0, scale_q24} + (41'd1 << 23);
            kmh     = (product[40:24] > 17'd999) ? 999 : product[40:24];
            hund    = kmh / 100;
            tens    = (kmh / 10) % 10;
            units   = kmh % 10;
            // Leading zeros stay blank; the units digit is always drawn.
            for (p = 0; p < 3; p++)
            begin
                digit = (p == 0) ? hund : (p == 1) ? tens : units;
                shown = (p == 2) || (p == 1 && (hund != 0 || tens != 0)) ||
                        (p == 0 && hund != 0);
                if (shown)
                begin
                    cells = digit_cells(4'(digit));
                    for (i = 0; i < 3; i++)
                    begin
                        rows[1][4 + 4 * p + i] = cells[47 - 8 * i -: 8];
                        rows[2][4 + 4 * p + i] = cells[23 - 8 * i -: 8];
                    end
                end
            end
        end

        // Each row is a cursor command followed by its twenty characters.
        k = 0;
        for (r = 0; r < 3; r++)
        begin
            base = (r == 0) ? ROW0_BASE : (r == 1) ? ROW1_BASE : ROW2_BASE;
            writes_due.push_back(expander_write(CMD_SET_DDRAM | base, 1'b0, k));
            k++;
            for (c = 0; c < COLS; c++)
            begin
                writes_due.push_back(expander_write(rows[r][c], 1'b1, k));
                k++;
            end
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Writes are compared before new requests are queued, so a write that
    // overtakes its own request is caught as unexpected.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q24   <= SPEED_SCALE_RESET;
            zero_offset <= RPM_OFFSET_RESET;
            age_limit   <= STALE_LIMIT_RESET;
            writes_due.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (writes_due.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS)
                        $display("%0t: write expected none, actual byte 0x%0h", $time,
                                 lcd_byte);
                end
                else
                begin
                    oldest = writes_due.pop_front();
                    checked_total++;
                    check_field("is_data", oldest.is_data, is_data);
                    check_field("lcd_byte", oldest.lcd_byte, lcd_byte);
                    check_field("wire0", oldest.wire0, wire0);
                    check_field("wire1", oldest.wire1, wire1);
                    check_field("wire2", oldest.wire2, wire2);
                    check_field("wire3", oldest.wire3, wire3);
                    check_field("last_of_frame", oldest.last_of_frame, last_of_frame);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SPEED_SCALE: scale_q24   <= cfg_data;
                    CFG_RPM_OFFSET:  zero_offset <= cfg_data[15:0];
                    CFG_STALE_LIMIT: age_limit   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                render_frame(data_valid, now_ms, last_rx_ms, rpm_raw, charge_raw);

            pending = writes_due.size();
        end
    end

endmodule

@@ dv/speed_soc_lcd_frame_formatter_tb.sv @@
// Testbench top for the speed and charge LCD frame formatter: clock, reset,
// stimulus and verdict. Depends on sslcd_pkg, the block and lcd_frame_checker.
`timescale 1ns / 1ps

module speed_soc_lcd_frame_formatter_tb;

    import sslcd_pkg::*;

    localparam logic [1:0] CFG_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         MAX_GAP         = 40;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 11;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        data_valid = 1'b0;
    logic [31:0] now_ms     = '0;
    logic [31:0] last_rx_ms = '0;
    logic [15:0] rpm_raw    = '0;
    logic [9:0]  charge_raw = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        is_data;
    logic [7:0]  lcd_byte;
    logic [7:0]  wire0;
    logic [7:0]  wire1;
    logic [7:0]  wire2;
    logic [7:0]  wire3;
    logic        last_of_frame;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = CFG_SPEED_SCALE;
    logic [23:0] cfg_data   = '0;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles       = 0;
    int          requests_sent      = 0;
    int          settings_applied   = 0;
    logic [15:0] cur_offset         = RPM_OFFSET_RESET;
    logic [15:0] cur_limit          = STALE_LIMIT_RESET;
    int          mismatches;
    int          writes_pending;
    int          writes_checked;

    always #5 clk = ~clk;

    speed_soc_lcd_frame_formatter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_valid    (data_valid),
        .now_ms        (now_ms),
        .last_rx_ms    (last_rx_ms),
        .rpm_raw       (rpm_raw),
        .charge_raw    (charge_raw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_data       (is_data),
        .lcd_byte      (lcd_byte),
        .wire0         (wire0),
        .wire1         (wire1),
        .wire2         (wire2),
        .wire3         (wire3),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lcd_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_valid         (data_valid),
        .now_ms             (now_ms),
        .last_rx_ms         (last_rx_ms),
        .rpm_raw            (rpm_raw),
        .charge_raw         (charge_raw),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .is_data            (is_data),
        .lcd_byte           (lcd_byte),
        .wire0              (wire0),
        .wire1              (wire1),
        .wire2              (wire2),
        .wire3              (wire3),
        .last_of_frame      (last_of_frame),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_count     (mismatches),
        .writes_outstanding (writes_pending),
        .writes_checked     (writes_checked)
    );

    // The display side stalls at random with the current phase's probability.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("speed_soc_lcd_frame_formatter: mismatch");
            $finish;
        end
    end

    // Entered and left at a falling edge. Valid is left high after the
    // transaction; the next call either replaces the payload or lowers it.
    task automatic send_request(input logic valid, input logic [31:0] now_tick,
                                input logic [31:0] rx_tick, input logic [15:0] rpm,
                                input logic [9:0] charge);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_valid <= valid;
        now_ms     <= now_tick;
        last_rx_ms <= rx_tick;
        rpm_raw    <= rpm;
        charge_raw <= charge;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
        @(negedge clk);
    endtask

    // Drops the request valid and waits until every predicted write is out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (writes_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Writes all three registers while idle, with junk above the 16-bit fields
    // and a write to the unused index that must change nothing.
    task automatic apply_setting(input logic [23:0] scale, input logic [15:0] offset,
                                 input logic [15:0] limit);
        wait_idle();
        write_register(CFG_SPEED_SCALE, scale);
        write_register(CFG_RPM_OFFSET, {8'($urandom), offset});
        write_register(CFG_STALE_LIMIT, {8'($urandom), limit});
        write_register(CFG_UNUSED, 24'($urandom));
        cur_offset = offset;
        cur_limit  = limit;
        settings_applied++;
    endtask

    // Mostly fresh requests so the speed rows get drawn, with ages on and just
    // past the limit, some far past it, and an occasional cleared valid flag.
    task automatic send_random_request();
        int unsigned pick;
        int unsigned age;
        logic [31:0] now_tick;
        logic [15:0] rpm;
        logic [9:0]  charge;
        pick     = $urandom_range(99);
        now_tick = $urandom();
        if (pick < 70)
            age = $urandom_range(cur_limit);
        else if (pick < 80)
            age = cur_limit;
        else if (pick < 90)
            age = cur_limit + 1;
        else
            age = $urandom();
        if ($urandom_range(2) == 0)
            rpm = 16'($urandom());
        else
            rpm = cur_offset + 16'($urandom_range(2000)) - 16'd1000;
        if ($urandom_range(15) == 0)
            charge = 10'($urandom_range(1023, 1001));
        else
            charge = 10'($urandom_range(1000));
        send_request($urandom_range(9) != 0, now_tick, now_tick - age, rpm, charge);
    endtask

    initial
    begin
        int p;
        int n;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: stale by flag, by age on and past the limit, a
        // wrapped tick counter, speed below the offset, charge boundaries.
        send_request(1'b0, 32'd1000, 32'd900, 16'd20000, 10'd500);
        send_request(1'b1, 32'd5000, 32'd3000, 16'd20000, 10'd0);
        send_request(1'b1, 32'd5001, 32'd3000, 16'd20000, 10'd0);
        send_request(1'b1, 32'h0000_0064, 32'hFFFF_FF00, 16'd0, 10'd5);
        send_request(1'b1, 32'd0, 32'd1, 16'hFFFF, 10'd1000);
        send_request(1'b1, 32'd7, 32'd7, 16'hFFFF, 10'd1000);
        send_request(1'b1, 32'd7, 32'd7, 16'd25331, 10'd99);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd20001, 10'd100);
        send_request(1'b1, 32'd9, 32'd8, 16'd19999, 10'd999);
        send_request(1'b1, 32'd9, 32'd8, 16'd30000, 10'd1001);
        send_request(1'b1, 32'd9, 32'd8, 16'd40000, 10'h3FF);

        // Full scale, no offset, zero age limit: speed follows the raw value,
        // saturates at 999 and shows every digit and blanking case.
        apply_setting(24'hFFFFFF, 16'd0, 16'd0);
        send_request(1'b1, 32'd42, 32'd42, 16'd999, 10'd321);
        send_request(1'b1, 32'd43, 32'd42, 16'd999, 10'd321);
        send_request(1'b1, 32'd50, 32'd50, 16'd1000, 10'd654);
        send_request(1'b1, 32'd50, 32'd50, 16'hFFFF, 10'd987);
        send_request(1'b1, 32'd50, 32'd50, 16'd100, 10'd1);
        send_request(1'b1, 32'd50, 32'd50, 16'd5, 10'd10);
        send_request(1'b1, 32'd50, 32'd50, 16'd0, 10'd0);
        send_request(1'b1, 32'd50, 32'd50, 16'd203, 10'd555);
        send_request(1'b1, 32'd50, 32'd50, 16'd456, 10'd777);
        send_request(1'b1, 32'd50, 32'd50, 16'd870, 10'd888);

        // Random requests under several settings and pacing modes.
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 5)
                0: apply_setting(SPEED_SCALE_RESET, RPM_OFFSET_RESET, STALE_LIMIT_RESET);
                1: apply_setting(24'hFFFFFF, 16'd0, 16'd0);
                2: apply_setting(24'd0, 16'hFFFF, 16'hFFFF);
                3: apply_setting(24'h800000, 16'd0, 16'd1000);
                default: apply_setting(24'($urandom), 16'($urandom), 16'($urandom));
            endcase
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
                default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d refresh requests under %0d register settings and four",
                 requests_sent, settings_applied + 1);
        $display("pacing modes; %0d display writes were compared.", writes_checked);
        if (mismatches == 0 && writes_pending == 0)
            $display("speed_soc_lcd_frame_formatter: match");
        else
            $display("speed_soc_lcd_frame_formatter: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/sslcd_pkg.sv
design/sslcd_front.sv
design/sslcd_queue.sv
design/sslcd_back.sv
design/speed_soc_lcd_frame_formatter.sv
dv/lcd_frame_checker.sv
dv/speed_soc_lcd_frame_formatter_tb.sv
